### sv/dfch_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the dimmer command frame handler.
// No dependencies; used by every module of the block.
package dfch_pkg;

    // Header codes
    localparam logic [7:0] HDR_INIT     = 8'hF0;
    localparam logic [3:0] NIB_STOP     = 4'h1;
    localparam logic [3:0] NIB_GQUERY   = 4'h2;
    localparam logic [3:0] NIB_DQUERY   = 4'h3;
    localparam logic [3:0] NIB_SET      = 4'h4;

    // Sub-command codes (low nibble of opt_a)
    localparam logic [3:0] SUB_SWITCH   = 4'h1;
    localparam logic [3:0] SUB_DUTY     = 4'h2;
    localparam logic [3:0] SUB_ON_TIME  = 4'h3;
    localparam logic [3:0] SUB_OFF_TIME = 4'h4;
    localparam logic [3:0] SUB_CLOCK    = 4'h5;

    // Reply kinds
    localparam logic [2:0] REPLY_NONE   = 3'd0;
    localparam logic [2:0] REPLY_PWRUP  = 3'd1;
    localparam logic [2:0] REPLY_GLOBAL = 3'd2;
    localparam logic [2:0] REPLY_DETAIL = 3'd3;
    localparam logic [2:0] REPLY_SET    = 3'd4;

    localparam logic [7:0] PWRUP_CMD    = 8'h01;
    localparam logic [7:0] DUTY_DEFAULT = 8'd100;
    localparam int         REPLY_OPTS   = 7;
    localparam int         QUEUE_DEPTH  = 2;

    // Command class decoded by the front end
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_STOP,
        KIND_GQUERY,
        KIND_DQUERY,
        KIND_SET
    } t_kind;

    typedef enum logic [2:0] {
        DQ_STATUS,
        DQ_DUTY,
        DQ_ON,
        DQ_OFF,
        DQ_BAD
    } t_dq;

    typedef enum logic [2:0] {
        SET_SWITCH,
        SET_DUTY,
        SET_ON,
        SET_OFF,
        SET_CLOCK,
        SET_BAD
    } t_set;

    // Classified frame word carried through the queue
    typedef struct packed {
        t_kind      kind;
        logic       init_hdr;
        t_dq        dq;
        t_set       set;
        logic [7:0] header;
        logic [7:0] group_class;
        logic [7:0] opt_a;
        logic [7:0] opt_b;
        logic [7:0] opt_c;
        logic [7:0] opt_d;
    } t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [2:0]                  number;
        logic [7:0]                  command;
        logic [REPLY_OPTS-1:0][7:0]  opts;
        logic                        restart;
    } t_reply;

endpackage

### sv/dfch_front.sv
`timescale 1ns / 1ps
// Front end: takes a frame word on start and classifies it for the queue.
// Depends on dfch_pkg.
module dfch_front (
    input  logic                 start,
    output logic                 busy,
    input  logic [7:0]           i_header,
    input  logic [7:0]           i_group_class,
    input  logic [7:0]           i_opt_a,
    input  logic [7:0]           i_opt_b,
    input  logic [7:0]           i_opt_c,
    input  logic [7:0]           i_opt_d,
    input  dfch_pkg::t_q_status  i_q_status,
    output logic                 o_push,
    output dfch_pkg::t_frame     o_frame
);
    import dfch_pkg::*;

    // Take a word whenever the queue has room
    assign busy   = i_q_status.full;
    assign o_push = start && !i_q_status.full;

    // Classify header and sub-command
    always_comb begin
        o_frame             = '0;
        o_frame.header      = i_header;
        o_frame.group_class = i_group_class;
        o_frame.opt_a       = i_opt_a;
        o_frame.opt_b       = i_opt_b;
        o_frame.opt_c       = i_opt_c;
        o_frame.opt_d       = i_opt_d;
        o_frame.init_hdr    = (i_header == HDR_INIT);

        case (i_header[3:0])
            NIB_STOP:   o_frame.kind = KIND_STOP;
            NIB_GQUERY: o_frame.kind = KIND_GQUERY;
            NIB_DQUERY: o_frame.kind = KIND_DQUERY;
            NIB_SET:    o_frame.kind = KIND_SET;
            default:    o_frame.kind = KIND_NONE;
        endcase

        // Detailed query needs the whole byte to match
        o_frame.dq = DQ_BAD;
        if (i_opt_a[7:4] == 4'h0) begin
            case (i_opt_a[3:0])
                SUB_SWITCH:   o_frame.dq = DQ_STATUS;
                SUB_DUTY:     o_frame.dq = DQ_DUTY;
                SUB_ON_TIME:  o_frame.dq = DQ_ON;
                SUB_OFF_TIME: o_frame.dq = DQ_OFF;
                default:      o_frame.dq = DQ_BAD;
            endcase
        end

        // Set command looks at the low nibble only
        case (i_opt_a[3:0])
            SUB_SWITCH:   o_frame.set = SET_SWITCH;
            SUB_DUTY:     o_frame.set = SET_DUTY;
            SUB_ON_TIME:  o_frame.set = SET_ON;
            SUB_OFF_TIME: o_frame.set = SET_OFF;
            SUB_CLOCK:    o_frame.set = SET_CLOCK;
            default:      o_frame.set = SET_BAD;
        endcase
    end

endmodule

### sv/dfch_queue.sv
`timescale 1ns / 1ps
// Short queue of classified frame words between front end and executor.
// Depends on dfch_pkg.
module dfch_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  dfch_pkg::t_frame     i_frame,
    input  logic                 i_pop,
    output dfch_pkg::t_frame     o_frame,
    output dfch_pkg::t_q_status  o_status
);
    import dfch_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_frame             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_wr;
    logic               do_rd;

    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_wr = i_push && !o_status.full;
    assign do_rd = i_pop && !o_status.empty;
    assign o_frame = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

### sv/dfch_exec.sv
`timescale 1ns / 1ps
// Executor: carries out one classified word a cycle, keeps all dimmer state
// and the reply record, and strobes the reply. Depends on dfch_pkg.
module dfch_exec #(
    parameter int TIMER_ENTRIES = 16,
    parameter int STATUS_BITS   = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  dfch_pkg::t_frame  i_frame,
    output logic              o_pop,
    output logic              o_valid,
    output dfch_pkg::t_reply  o_reply
);
    import dfch_pkg::*;

    localparam int         IDX_W   = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1;
    localparam logic [4:0] ENT_LIM = 5'(TIMER_ENTRIES);

    // State
    logic                    r_link_ready;
    logic [7:0]              r_duty_now;
    logic [7:0]              r_duty_saved;
    logic [STATUS_BITS-1:0]  r_switch_bits;
    logic [7:0]              r_on_hour   [TIMER_ENTRIES];
    logic [7:0]              r_on_minute [TIMER_ENTRIES];
    logic [7:0]              r_off_hour  [TIMER_ENTRIES];
    logic [7:0]              r_off_minute[TIMER_ENTRIES];
    logic [7:0]              r_entry_ck  [TIMER_ENTRIES];
    logic [7:0]              r_total_ck;
    logic [7:0]              r_clock_hour;
    logic [7:0]              r_clock_minute;
    logic [7:0]              r_clock_second;
    t_reply                  r_reply;
    logic                    r_valid;

    // Next values
    logic                    n_link_ready;
    logic [7:0]              n_duty_now;
    logic [7:0]              n_duty_saved;
    logic [STATUS_BITS-1:0]  n_switch_bits;
    logic [7:0]              n_total_ck;
    logic [7:0]              n_clock_hour;
    logic [7:0]              n_clock_minute;
    logic [7:0]              n_clock_second;
    t_reply                  n_reply;
    logic                    tmr_we;
    logic                    tmr_on;
    logic [7:0]              n_entry_ck;

    logic [IDX_W-1:0]        idx;
    logic                    cls_ok;
    logic [3:0]              grp;
    logic [15:0]             sw_ext;
    logic [7:0]              old_h;
    logic [7:0]              old_m;

    assign o_pop   = i_avail;
    assign o_valid = r_valid;
    assign o_reply = r_reply;

    assign grp    = i_frame.group_class[7:4];
    assign idx    = i_frame.group_class[IDX_W-1:0];
    assign cls_ok = ({1'b0, i_frame.group_class[3:0]} < ENT_LIM);
    assign sw_ext = 16'(r_switch_bits);

    // Old timer pair for a write to the selected class
    assign tmr_on = (i_frame.set == SET_ON);
    assign old_h  = tmr_on ? r_on_hour[idx]   : r_off_hour[idx];
    assign old_m  = tmr_on ? r_on_minute[idx] : r_off_minute[idx];
    assign n_entry_ck = r_entry_ck[idx] ^ old_h ^ old_m ^ i_frame.opt_b ^ i_frame.opt_c;

    // Command execution
    always_comb begin
        n_link_ready   = r_link_ready;
        n_duty_now     = r_duty_now;
        n_duty_saved   = r_duty_saved;
        n_switch_bits  = r_switch_bits;
        n_total_ck     = r_total_ck;
        n_clock_hour   = r_clock_hour;
        n_clock_minute = r_clock_minute;
        n_clock_second = r_clock_second;
        n_reply        = r_reply;
        n_reply.restart = 1'b0;
        tmr_we         = 1'b0;

        if (i_frame.init_hdr && !r_link_ready) begin
            // Link arm and power-up reply
            n_link_ready    = 1'b1;
            n_reply.number  = REPLY_PWRUP;
            n_reply.command = PWRUP_CMD;
            n_reply.opts    = '0;
            n_reply.restart = 1'b1;
        end else begin
            case (i_frame.kind)
                KIND_STOP: begin
                    n_reply.number = REPLY_NONE;
                end
                KIND_GQUERY: begin
                    n_reply.number  = REPLY_GLOBAL;
                    n_reply.command = i_frame.header;
                    n_reply.opts    = '0;
                    n_reply.opts[0] = sw_ext[7:0];
                    n_reply.opts[1] = r_duty_now;
                    n_reply.opts[2] = r_total_ck;
                    n_reply.restart = 1'b1;
                end
                KIND_DQUERY: begin
                    n_reply.number  = REPLY_DETAIL;
                    n_reply.command = i_frame.header;
                    if (i_frame.dq == DQ_BAD) begin
                        n_reply.number = REPLY_NONE;
                    end else begin
                        n_reply.opts    = '0;
                        n_reply.opts[0] = i_frame.group_class;
                        n_reply.opts[1] = i_frame.opt_a;
                        case (i_frame.dq)
                            DQ_STATUS: n_reply.opts[2] = {7'd0, sw_ext[grp]};
                            DQ_DUTY:   n_reply.opts[2] = r_duty_now;
                            DQ_ON: begin
                                if (cls_ok) begin
                                    n_reply.opts[2] = r_on_hour[idx];
                                    n_reply.opts[3] = r_on_minute[idx];
                                end
                            end
                            DQ_OFF: begin
                                if (cls_ok) begin
                                    n_reply.opts[2] = r_off_hour[idx];
                                    n_reply.opts[3] = r_off_minute[idx];
                                end
                            end
                            default: n_reply.opts[2] = '0;
                        endcase
                    end
                end
                KIND_SET: begin
                    n_reply.number  = REPLY_SET;
                    n_reply.command = i_frame.header;
                    n_reply.opts    = '0;
                    n_reply.opts[0] = i_frame.group_class;
                    n_reply.opts[1] = i_frame.opt_a;
                    case (i_frame.set)
                        SET_SWITCH: begin
                            if (i_frame.opt_b == 8'd0) begin
                                n_duty_saved     = r_duty_now;
                                n_duty_now       = 8'd0;
                                n_switch_bits[0] = 1'b0;
                            end else begin
                                // Switch on with nothing saved falls back to default
                                if (r_duty_saved == 8'd0) begin
                                    n_duty_now   = DUTY_DEFAULT;
                                    n_duty_saved = DUTY_DEFAULT;
                                end else begin
                                    n_duty_now   = r_duty_saved;
                                end
                                n_switch_bits[0] = 1'b1;
                            end
                        end
                        SET_DUTY: begin
                            n_duty_now       = i_frame.opt_b;
                            n_duty_saved     = i_frame.opt_b;
                            n_switch_bits[0] = (i_frame.opt_b != 8'd0);
                        end
                        SET_ON, SET_OFF: begin
                            if (cls_ok) begin
                                tmr_we     = 1'b1;
                                n_total_ck = r_total_ck ^ r_entry_ck[idx] ^ n_entry_ck;
                            end
                        end
                        SET_CLOCK: begin
                            n_clock_hour   = i_frame.opt_b;
                            n_clock_minute = i_frame.opt_c;
                            n_clock_second = i_frame.opt_d;
                        end
                        default: n_reply.number = REPLY_NONE;
                    endcase
                end
                default: n_reply.number = r_reply.number;
            endcase
        end
    end

    // State and reply registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_ready   <= 1'b0;
            r_duty_now     <= '0;
            r_duty_saved   <= '0;
            r_switch_bits  <= '0;
            r_total_ck     <= '0;
            r_clock_hour   <= '0;
            r_clock_minute <= '0;
            r_clock_second <= '0;
            r_reply        <= '0;
            r_valid        <= 1'b0;
            for (int i = 0; i < TIMER_ENTRIES; i++) begin
                r_on_hour[i]    <= '0;
                r_on_minute[i]  <= '0;
                r_off_hour[i]   <= '0;
                r_off_minute[i] <= '0;
                r_entry_ck[i]   <= '0;
            end
        end else begin
            r_valid <= i_avail;
            if (i_avail) begin
                r_link_ready   <= n_link_ready;
                r_duty_now     <= n_duty_now;
                r_duty_saved   <= n_duty_saved;
                r_switch_bits  <= n_switch_bits;
                r_total_ck     <= n_total_ck;
                r_clock_hour   <= n_clock_hour;
                r_clock_minute <= n_clock_minute;
                r_clock_second <= n_clock_second;
                r_reply        <= n_reply;
                if (tmr_we) begin
                    r_entry_ck[idx] <= n_entry_ck;
                    if (tmr_on) begin
                        r_on_hour[idx]   <= i_frame.opt_b;
                        r_on_minute[idx] <= i_frame.opt_c;
                    end else begin
                        r_off_hour[idx]   <= i_frame.opt_b;
                        r_off_minute[idx] <= i_frame.opt_c;
                    end
                end
            end
        end
    end

endmodule

### sv/dimmer_command_frame_handler_top.sv
`timescale 1ns / 1ps
// Top level of the dimmer command frame handler: front end, queue, executor.
// Depends on dfch_pkg, dfch_front, dfch_queue, dfch_exec.
//
//  Channel   Handshake                Payload
//  -------   ----------------------   ----------------------------------------
//  command   start in, busy out       i_header, i_group_class, i_opt_a..d
//  reply     o_reply_valid (strobe)   o_reply_number, o_reply_command,
//                                     o_reply_byte0..6, o_restart_repeat
//
// A word taken at an edge is classified and written into the queue storage; the
// executor carries it out from the queue head and registers its reply and strobe.
// The executor retires one word per cycle, so a word may be issued every
// cycle; busy rises only if the two-entry queue fills.
// Reset (synchronous) clears the queue, all dimmer state, the timer table
// and the reply record. The reply side has no stall.
module dimmer_command_frame_handler_top #(
    parameter int TIMER_ENTRIES = 16,
    parameter int STATUS_BITS   = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_header,
    input  logic [7:0] i_group_class,
    input  logic [7:0] i_opt_a,
    input  logic [7:0] i_opt_b,
    input  logic [7:0] i_opt_c,
    input  logic [7:0] i_opt_d,
    output logic       o_reply_valid,
    output logic [2:0] o_reply_number,
    output logic [7:0] o_reply_command,
    output logic [7:0] o_reply_byte0,
    output logic [7:0] o_reply_byte1,
    output logic [7:0] o_reply_byte2,
    output logic [7:0] o_reply_byte3,
    output logic [7:0] o_reply_byte4,
    output logic [7:0] o_reply_byte5,
    output logic [7:0] o_reply_byte6,
    output logic       o_restart_repeat
);
    import dfch_pkg::*;

    t_frame    front_frame;
    t_frame    queue_frame;
    t_q_status q_status;
    t_reply    reply;
    logic      push;
    logic      pop;

    dfch_front u_front (
        .start         (start),
        .busy          (busy),
        .i_header      (i_header),
        .i_group_class (i_group_class),
        .i_opt_a       (i_opt_a),
        .i_opt_b       (i_opt_b),
        .i_opt_c       (i_opt_c),
        .i_opt_d       (i_opt_d),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_frame       (front_frame)
    );

    dfch_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_frame  (front_frame),
        .i_pop    (pop),
        .o_frame  (queue_frame),
        .o_status (q_status)
    );

    dfch_exec #(
        .TIMER_ENTRIES (TIMER_ENTRIES),
        .STATUS_BITS   (STATUS_BITS)
    ) u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (!q_status.empty),
        .i_frame (queue_frame),
        .o_pop   (pop),
        .o_valid (o_reply_valid),
        .o_reply (reply)
    );

    // Reply record onto the ports
    assign o_reply_number   = reply.number;
    assign o_reply_command  = reply.command;
    assign o_reply_byte0    = reply.opts[0];
    assign o_reply_byte1    = reply.opts[1];
    assign o_reply_byte2    = reply.opts[2];
    assign o_reply_byte3    = reply.opts[3];
    assign o_reply_byte4    = reply.opts[4];
    assign o_reply_byte5    = reply.opts[5];
    assign o_reply_byte6    = reply.opts[6];
    assign o_restart_repeat = reply.restart;

endmodule

### sv/dfch_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the dimmer command frame handler, bound to the top.
// Depends on dfch_pkg and dimmer_command_frame_handler_top.
module dfch_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_reply_valid,
    input logic [2:0] o_reply_number,
    input logic [7:0] o_reply_command,
    input logic [7:0] o_reply_byte0,
    input logic       o_restart_repeat
);
    import dfch_pkg::*;

    logic accepted;
    assign accepted = start && !busy && i_rst_n;

    // Every accepted word gets its reply strobe
    a_reply_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accepted ##1 i_rst_n |=> o_reply_valid)
        else $error("accepted word produced no reply");

    // No reply strobe without an earlier accepted word
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_reply_valid |-> $past(accepted, 2))
        else $error("reply strobe without accepted word");

    // A restart only comes with a power-up or global reply
    a_restart_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_reply_valid && o_restart_repeat |->
            (o_reply_number == REPLY_PWRUP || o_reply_number == REPLY_GLOBAL))
        else $error("restart with wrong reply kind");

    // Power-up reply carries its fixed command and cleared options
    a_pwrup_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_reply_valid && o_restart_repeat && o_reply_number == REPLY_PWRUP |->
            (o_reply_command == PWRUP_CMD && o_reply_byte0 == 8'h00))
        else $error("bad power-up reply record");

    // Reply kind stays in range
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_reply_valid |-> (o_reply_number <= REPLY_SET))
        else $error("reply kind out of range");

endmodule

bind dimmer_command_frame_handler_top dfch_checker u_dfch_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_reply_valid    (o_reply_valid),
    .o_reply_number   (o_reply_number),
    .o_reply_command  (o_reply_command),
    .o_reply_byte0    (o_reply_byte0),
    .o_restart_repeat (o_restart_repeat)
);

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for dimmer_command_frame_handler_top: frames are driven
// from a queue, replies checked against an in-bench predictor of the handler.
// Depends on dfch_pkg and the handler RTL.
module tb;
    import dfch_pkg::*;

    localparam int TIMER_ENTRIES = 16;
    localparam int STATUS_BITS   = 8;
    localparam int RANDOM_WORDS  = 1700;
    localparam int STALL_LIMIT   = 1000;
    localparam int MAX_REPORTS   = 10;

    // Detailed query selectors (whole opt_a byte)
    localparam logic [7:0] SEL_STATUS = 8'd1;
    localparam logic [7:0] SEL_DUTY   = 8'd2;
    localparam logic [7:0] SEL_ON     = 8'd3;
    localparam logic [7:0] SEL_OFF    = 8'd4;

    // One command word plus a flag that makes the sender wait for all replies
    typedef struct {
        logic [7:0] header;
        logic [7:0] group_class;
        logic [7:0] opt_a;
        logic [7:0] opt_b;
        logic [7:0] opt_c;
        logic [7:0] opt_d;
        bit         hold;
    } t_cmd_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [7:0] i_header = 8'h00;
    logic [7:0] i_group_class = 8'h00;
    logic [7:0] i_opt_a = 8'h00;
    logic [7:0] i_opt_b = 8'h00;
    logic [7:0] i_opt_c = 8'h00;
    logic [7:0] i_opt_d = 8'h00;
    logic       o_reply_valid;
    logic [2:0] o_reply_number;
    logic [7:0] o_reply_command;
    logic [7:0] o_reply_byte0;
    logic [7:0] o_reply_byte1;
    logic [7:0] o_reply_byte2;
    logic [7:0] o_reply_byte3;
    logic [7:0] o_reply_byte4;
    logic [7:0] o_reply_byte5;
    logic [7:0] o_reply_byte6;
    logic       o_restart_repeat;

    t_cmd_word frame_queue[$];
    t_reply    expected_replies[$];
    int        sent_count = 0;
    int        accept_count = 0;
    int        mismatch_count = 0;
    int        stall_cycles = 0;

    // Predicted handler state
    logic                       link_up;
    logic [7:0]                 duty_level;
    logic [7:0]                 duty_saved;
    logic [STATUS_BITS-1:0]     status_bits;
    logic [7:0]                 on_hour [TIMER_ENTRIES];
    logic [7:0]                 on_min [TIMER_ENTRIES];
    logic [7:0]                 off_hour [TIMER_ENTRIES];
    logic [7:0]                 off_min [TIMER_ENTRIES];
    logic [7:0]                 entry_sum [TIMER_ENTRIES];
    logic [7:0]                 total_sum;
    logic [7:0]                 rtc_hour;
    logic [7:0]                 rtc_min;
    logic [7:0]                 rtc_sec;
    logic [2:0]                 rec_number;
    logic [7:0]                 rec_command;
    logic [REPLY_OPTS-1:0][7:0] rec_opts;

    dimmer_command_frame_handler_top #(
        .TIMER_ENTRIES(TIMER_ENTRIES),
        .STATUS_BITS  (STATUS_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_header        (i_header),
        .i_group_class   (i_group_class),
        .i_opt_a         (i_opt_a),
        .i_opt_b         (i_opt_b),
        .i_opt_c         (i_opt_c),
        .i_opt_d         (i_opt_d),
        .o_reply_valid   (o_reply_valid),
        .o_reply_number  (o_reply_number),
        .o_reply_command (o_reply_command),
        .o_reply_byte0   (o_reply_byte0),
        .o_reply_byte1   (o_reply_byte1),
        .o_reply_byte2   (o_reply_byte2),
        .o_reply_byte3   (o_reply_byte3),
        .o_reply_byte4   (o_reply_byte4),
        .o_reply_byte5   (o_reply_byte5),
        .o_reply_byte6   (o_reply_byte6),
        .o_restart_repeat(o_restart_repeat)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Clear reply options from index 'from' upward
    function automatic void clear_opts_from(int from);
        for (int k = from; k < REPLY_OPTS; k++) begin
            rec_opts[k] = 8'h00;
        end
    endfunction

    // Timer write keeps per-entry and total XOR sums in step
    function automatic void write_timer(logic [3:0] cls, bit on, logic [7:0] hr,
                                        logic [7:0] mn);
        if (cls >= TIMER_ENTRIES) return;
        total_sum = total_sum ^ entry_sum[cls];
        if (on) begin
            entry_sum[cls] = entry_sum[cls] ^ on_hour[cls] ^ on_min[cls];
            on_hour[cls] = hr;
            on_min[cls] = mn;
        end else begin
            entry_sum[cls] = entry_sum[cls] ^ off_hour[cls] ^ off_min[cls];
            off_hour[cls] = hr;
            off_min[cls] = mn;
        end
        entry_sum[cls] = entry_sum[cls] ^ hr ^ mn;
        total_sum = total_sum ^ entry_sum[cls];
    endfunction

    // Apply one command word to the predicted state; return the reply it yields
    function automatic t_reply apply_frame(t_cmd_word w);
        t_reply     r;
        logic [3:0] grp;
        logic [3:0] cls;
        bit         restart;
        grp = w.group_class[7:4];
        cls = w.group_class[3:0];
        restart = 1'b0;
        if (!link_up && w.header == HDR_INIT) begin
            link_up = 1'b1;
            rec_number = REPLY_PWRUP;
            rec_command = PWRUP_CMD;
            clear_opts_from(0);
            restart = 1'b1;
        end else begin
            case (w.header[3:0])
                NIB_STOP: begin
                    rec_number = REPLY_NONE;
                end
                NIB_GQUERY: begin
                    rec_number = REPLY_GLOBAL;
                    rec_command = w.header;
                    rec_opts[0] = 8'(status_bits);
                    rec_opts[1] = duty_level;
                    rec_opts[2] = total_sum;
                    clear_opts_from(3);
                    restart = 1'b1;
                end
                NIB_DQUERY: begin
                    rec_number = REPLY_DETAIL;
                    rec_command = w.header;
                    if (w.opt_a >= SEL_STATUS && w.opt_a <= SEL_OFF) begin
                        rec_opts[0] = w.group_class;
                        rec_opts[1] = w.opt_a;
                        clear_opts_from(2);
                        if (w.opt_a == SEL_STATUS) begin
                            rec_opts[2] = (grp < STATUS_BITS) ? {7'd0, status_bits[grp]} : 8'h00;
                        end else if (w.opt_a == SEL_DUTY) begin
                            rec_opts[2] = duty_level;
                        end else if (cls < TIMER_ENTRIES) begin
                            rec_opts[2] = (w.opt_a == SEL_ON) ? on_hour[cls] : off_hour[cls];
                            rec_opts[3] = (w.opt_a == SEL_ON) ? on_min[cls] : off_min[cls];
                        end
                    end else begin
                        rec_number = REPLY_NONE;
                    end
                end
                NIB_SET: begin
                    rec_number = REPLY_SET;
                    rec_command = w.header;
                    rec_opts[0] = w.group_class;
                    rec_opts[1] = w.opt_a;
                    clear_opts_from(2);
                    case (w.opt_a[3:0])
                        SUB_SWITCH: begin
                            if (w.opt_b == 8'h00) begin
                                duty_saved = duty_level;
                                duty_level = 8'h00;
                                status_bits[0] = 1'b0;
                            end else begin
                                duty_level = duty_saved;
                                // switching on with nothing saved falls back to default
                                if (duty_level == 8'h00) begin
                                    duty_level = DUTY_DEFAULT;
                                    duty_saved = DUTY_DEFAULT;
                                end
                                status_bits[0] = 1'b1;
                            end
                        end
                        SUB_DUTY: begin
                            duty_level = w.opt_b;
                            duty_saved = w.opt_b;
                            status_bits[0] = (w.opt_b != 8'h00);
                        end
                        SUB_ON_TIME:  write_timer(cls, 1'b1, w.opt_b, w.opt_c);
                        SUB_OFF_TIME: write_timer(cls, 1'b0, w.opt_b, w.opt_c);
                        SUB_CLOCK: begin
                            rtc_hour = w.opt_b;
                            rtc_min = w.opt_c;
                            rtc_sec = w.opt_d;
                        end
                        default: rec_number = REPLY_NONE;
                    endcase
                end
                default: ;
            endcase
        end
        r.number = rec_number;
        r.command = rec_command;
        r.opts = rec_opts;
        r.restart = restart;
        return r;
    endfunction

    function automatic void push_frame(logic [7:0] hdr, logic [7:0] gc, logic [7:0] a,
                                       logic [7:0] b, logic [7:0] c, logic [7:0] d,
                                       bit hold = 1'b0);
        t_cmd_word w;
        w.header = hdr;
        w.group_class = gc;
        w.opt_a = a;
        w.opt_b = b;
        w.opt_c = c;
        w.opt_d = d;
        w.hold = hold;
        frame_queue.push_back(w);
    endfunction

    // Mostly well-formed commands with random content, the rest noise
    function automatic t_cmd_word random_word();
        t_cmd_word   w;
        int unsigned pick;
        int unsigned sub_pick;
        w.header = 8'($urandom);
        w.group_class = 8'($urandom);
        w.opt_a = 8'($urandom);
        w.opt_b = 8'($urandom);
        w.opt_c = 8'($urandom);
        w.opt_d = 8'($urandom);
        w.hold = 1'b0;
        pick = $urandom_range(99);
        if (pick < 55) begin
            w.header[3:0] = NIB_SET;
            sub_pick = $urandom_range(99);
            if (sub_pick < 90) begin
                w.opt_a[3:0] = 4'($urandom_range(SUB_CLOCK, SUB_SWITCH));
                if (sub_pick < 70) w.opt_a[7:4] = 4'h0;
            end
            if ($urandom_range(3) == 0) w.opt_b = 8'h00;
        end else if (pick < 72) begin
            w.header[3:0] = NIB_DQUERY;
            if ($urandom_range(99) < 85) w.opt_a = 8'($urandom_range(SEL_OFF, SEL_STATUS));
        end else if (pick < 82) begin
            w.header[3:0] = NIB_GQUERY;
        end else if (pick < 88) begin
            w.header[3:0] = NIB_STOP;
        end else if (pick >= 97) begin
            w.header = HDR_INIT;
        end
        return w;
    endfunction

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("%0t: reply %s mismatch, expected %h got %h",
                         $time, name, want, got);
            end
        end
    endtask

    // Driver: presents the next word at the falling edge once the last one is taken
    always @(negedge i_clk) begin
        t_cmd_word w;
        bit        quiet;
        bit        idle;
        if (i_rst_n && (!start || accept_count == sent_count)) begin
            quiet = (sent_count >= 700 && sent_count < 1000);
            idle = !quiet && ($urandom_range(99) < 34);
            if (frame_queue.size() != 0 && !idle &&
                !(frame_queue[0].hold && expected_replies.size() != 0)) begin
                w = frame_queue.pop_front();
                start <= 1'b1;
                i_header <= w.header;
                i_group_class <= w.group_class;
                i_opt_a <= w.opt_a;
                i_opt_b <= w.opt_b;
                i_opt_c <= w.opt_c;
                i_opt_d <= w.opt_d;
                sent_count++;
            end else begin
                // no word this cycle: payload carries junk
                start <= 1'b0;
                i_header <= 8'($urandom);
                i_group_class <= 8'($urandom);
                i_opt_a <= 8'($urandom);
                i_opt_b <= 8'($urandom);
                i_opt_c <= 8'($urandom);
                i_opt_d <= 8'($urandom);
            end
        end
    end

    // Monitor: checks strobed replies, predicts accepted words, runs the watchdog
    always @(posedge i_clk) begin
        t_reply                     want;
        t_cmd_word                  w;
        logic [REPLY_OPTS-1:0][7:0] got_opts;
        bit                         progress;
        if (i_rst_n) begin
            progress = 1'b0;
            if (o_reply_valid !== 1'b0) begin
                progress = 1'b1;
                if (expected_replies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: reply strobe with no word pending", $time);
                    end
                end else begin
                    want = expected_replies.pop_front();
                    got_opts = {o_reply_byte6, o_reply_byte5, o_reply_byte4, o_reply_byte3,
                                o_reply_byte2, o_reply_byte1, o_reply_byte0};
                    check_field("number", {5'd0, o_reply_number}, {5'd0, want.number});
                    check_field("command", o_reply_command, want.command);
                    for (int k = 0; k < REPLY_OPTS; k++) begin
                        check_field($sformatf("byte%0d", k), got_opts[k], want.opts[k]);
                    end
                    check_field("restart", {7'd0, o_restart_repeat}, {7'd0, want.restart});
                end
            end
            if (start && busy === 1'b0) begin
                progress = 1'b1;
                w.header = i_header;
                w.group_class = i_group_class;
                w.opt_a = i_opt_a;
                w.opt_b = i_opt_b;
                w.opt_c = i_opt_c;
                w.opt_d = i_opt_d;
                w.hold = 1'b0;
                expected_replies.push_back(apply_frame(w));
                accept_count++;
            end
            stall_cycles = progress ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int word_count;
        t_cmd_word w;

        // predictor starts from the reset state
        link_up = 1'b0;
        duty_level = 8'h00;
        duty_saved = 8'h00;
        status_bits = '0;
        total_sum = 8'h00;
        rtc_hour = 8'h00;
        rtc_min = 8'h00;
        rtc_sec = 8'h00;
        rec_number = REPLY_NONE;
        rec_command = 8'h00;
        rec_opts = '0;
        for (int k = 0; k < TIMER_ENTRIES; k++) begin
            on_hour[k] = 8'h00;
            on_min[k] = 8'h00;
            off_hour[k] = 8'h00;
            off_min[k] = 8'h00;
            entry_sum[k] = 8'h00;
        end

        // Directed: commands decoded before init, then init and a repeat of it
        push_frame({4'h0, NIB_GQUERY}, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        push_frame({4'h3, NIB_SET}, 8'h10, {4'h0, SUB_DUTY}, 8'h40, 8'h00, 8'h00);
        push_frame({4'h0, NIB_DQUERY}, 8'h00, SEL_DUTY, 8'h00, 8'h00, 8'h00);
        push_frame(HDR_INIT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_frame(HDR_INIT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // switch on with nothing saved, off, on again
        push_frame({4'h0, NIB_SET}, 8'h00, {4'h0, SUB_DUTY}, 8'h00, 8'h00, 8'h00);
        push_frame({4'hF, NIB_SET}, 8'h00, {4'h0, SUB_SWITCH}, 8'h01, 8'h00, 8'h00);
        push_frame({4'h0, NIB_SET}, 8'h00, {4'h0, SUB_SWITCH}, 8'h00, 8'h00, 8'h00);
        push_frame({4'h0, NIB_SET}, 8'h00, {4'hF, SUB_SWITCH}, 8'hFF, 8'h00, 8'h00);
        // status for low, top-valid and out-of-range groups
        push_frame({4'h0, NIB_DQUERY}, 8'h00, SEL_STATUS, 8'h00, 8'h00, 8'h00);
        push_frame({4'h0, NIB_DQUERY}, 8'h70, SEL_STATUS, 8'h00, 8'h00, 8'h00);
        push_frame({4'hF, NIB_DQUERY}, 8'hF0, SEL_STATUS, 8'h00, 8'h00, 8'h00);
        // timer table at both ends, then read back
        push_frame({4'h0, NIB_SET}, 8'h00, {4'h0, SUB_ON_TIME}, 8'hFF, 8'hFF, 8'h00);
        push_frame({4'h0, NIB_SET}, 8'hFF, {4'h0, SUB_OFF_TIME}, 8'hFF, 8'h00, 8'hFF);
        push_frame({4'h0, NIB_DQUERY}, 8'h00, SEL_ON, 8'h00, 8'h00, 8'h00);
        push_frame({4'h0, NIB_DQUERY}, 8'h0F, SEL_OFF, 8'h00, 8'h00, 8'h00);
        // clock, unknown set and query selectors
        push_frame({4'h0, NIB_SET}, 8'h00, {4'h0, SUB_CLOCK}, 8'hFF, 8'hFF, 8'hFF);
        push_frame({4'h0, NIB_SET}, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33);
        push_frame({4'h0, NIB_SET}, 8'h00, 8'hFF, 8'h11, 8'h22, 8'h33);
        push_frame({4'h0, NIB_DQUERY}, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        push_frame({4'h0, NIB_DQUERY}, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00);
        // full duty, stop, global query after draining, ignored headers
        push_frame({4'h0, NIB_SET}, 8'h00, {4'h0, SUB_DUTY}, 8'hFF, 8'h00, 8'h00);
        push_frame({4'h0, NIB_STOP}, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        push_frame({4'hF, NIB_GQUERY}, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        push_frame(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_frame(8'h0F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        push_frame(8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

        // Random: mostly decoded commands, with noise and init headers mixed in
        word_count = 0;
        while (word_count < RANDOM_WORDS) begin
            w = random_word();
            if (word_count == RANDOM_WORDS / 2) w.hold = 1'b1;
            frame_queue.push_back(w);
            word_count++;
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (frame_queue.size() != 0 || accept_count != sent_count) @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatch_count == 0 && expected_replies.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
